>>> hw/rtl/fpr_pkg.sv
// Shared types, codes and constants of the FIFO page replacement core.
package fpr_pkg;

	localparam int FRAMES_DEF = 16;
	localparam int PAGE_BITS_DEF = 16;
	localparam int CFG_W = 5;
	localparam int TOTAL_W = 32;
	localparam logic [CFG_W-1:0] FRAME_COUNT_RST = 5'd4;

	typedef enum logic [1:0] {
		OUTCOME_HIT     = 2'd0,
		OUTCOME_LOAD    = 2'd1,
		OUTCOME_REPLACE = 2'd2
	} outcome_t;

	typedef struct packed {
		logic update;
		logic replace;
		logic in_use;
		logic tail;
	} cell_ctl_t;

	typedef struct packed {
		logic hit;
		logic load;
		logic decided;
	} cell_stat_t;

endpackage

>>> hw/rtl/fpr_cell.sv
// One frame cell: holds a resident page, compares it and shifts toward the head.
module fpr_cell #(
	parameter int PAGE_BITS = fpr_pkg::PAGE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fpr_pkg::cell_ctl_t    ctl,
	input  logic [PAGE_BITS-1:0]  page,
	input  logic [PAGE_BITS-1:0]  next_frame,
	input  logic                  decided_in,
	output fpr_pkg::cell_stat_t   stat,
	output logic [PAGE_BITS-1:0]  frame
);
	import fpr_pkg::*;

	logic [PAGE_BITS-1:0] frame_q;
	logic                 match;
	logic                 empty;
	logic                 claim;

	always_comb begin
		match        = (frame_q == page);
		empty        = (frame_q == '0);
		claim        = ctl.in_use && (match || empty);
		stat.decided = decided_in || claim;
		stat.hit     = claim && !decided_in && match;
		stat.load    = claim && !decided_in && !match;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
		end else if (ctl.update) begin
			if (stat.load) begin
				frame_q <= page;
			end else if (ctl.replace && ctl.in_use) begin
				frame_q <= ctl.tail ? page : next_frame;
			end
		end
	end

	assign frame = frame_q;

endmodule

>>> hw/rtl/fpr_tally.sv
// Saturating fault and request totals.
module fpr_tally (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic                        fault,
	output logic [fpr_pkg::TOTAL_W-1:0] fault_next,
	output logic [fpr_pkg::TOTAL_W-1:0] request_next
);
	import fpr_pkg::*;

	logic [TOTAL_W-1:0] fault_q;
	logic [TOTAL_W-1:0] request_q;

	always_comb begin
		request_next = (request_q == '1) ? request_q : request_q + 1'b1;
		if (fault) begin
			fault_next = (fault_q == '1) ? fault_q : fault_q + 1'b1;
		end else begin
			fault_next = fault_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_q   <= '0;
			request_q <= '0;
		end else if (accept) begin
			fault_q   <= fault_next;
			request_q <= request_next;
		end
	end

endmodule

>>> hw/rtl/fifo_page_replacement_core.sv
// Top level of the FIFO page replacement core: frame cell row, totals and result register.
//
// Usage: each input transaction carries one page_number. The block looks it up in the
// first frame_count frames (0 acts as 1, values above FRAMES act as FRAMES), then
// reports outcome (hit, load into an empty frame, or replacement of the oldest page),
// the evicted page and the saturating fault and request totals.
// Every cell compares its frame against the page in parallel; a ripple of claim
// signals along the row picks the first frame that holds the page or is empty.
// On replacement every frame in use takes its neighbor's page and the tail takes
// the new page, all in the same edge.
// Throughput is one transaction per cycle unless the output stalls; the result appears
// on the output channel in the cycle after acceptance, held in the output register.
// While the receiver stalls a waiting result, the input is stalled too.
// Reset empties every frame, clears both totals and sets frame_count to 4. The user
// writes the frame count via cfg_write and cfg_data while idle; the block does not enforce it.
module fifo_page_replacement_core #(
	parameter int FRAMES    = fpr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = fpr_pkg::PAGE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic [fpr_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [PAGE_BITS-1:0]        page_number,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  outcome,
	output logic [PAGE_BITS-1:0]        evicted_page,
	output logic [fpr_pkg::TOTAL_W-1:0] fault_total,
	output logic [fpr_pkg::TOTAL_W-1:0] request_total
);
	import fpr_pkg::*;

	localparam int NW = $clog2(FRAMES + 1);
	localparam int CW = (NW > CFG_W) ? NW : CFG_W;

	logic [CFG_W-1:0]     frame_count_q;
	logic [CW-1:0]        cfg_ext;
	logic [CW-1:0]        n_use;
	logic                 accept;
	logic                 replace;
	logic                 hit_any;
	logic                 load_any;
	logic [FRAMES:0]      dchain;
	logic [FRAMES-1:0]    hit_vec;
	logic [FRAMES-1:0]    load_vec;
	logic [PAGE_BITS-1:0] frames [FRAMES];
	cell_stat_t           stat [FRAMES];
	cell_ctl_t            ctl [FRAMES];
	outcome_t             outcome_next;
	logic [TOTAL_W-1:0]   fault_next;
	logic [TOTAL_W-1:0]   request_next;

	logic                 out_valid_q;
	outcome_t             outcome_q;
	logic [PAGE_BITS-1:0] evicted_q;
	logic [TOTAL_W-1:0]   fault_total_q;
	logic [TOTAL_W-1:0]   request_total_q;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		cfg_ext = CW'(frame_count_q);
		if (cfg_ext == '0) begin
			n_use = CW'(1);
		end else if (cfg_ext > CW'(FRAMES)) begin
			n_use = CW'(FRAMES);
		end else begin
			n_use = cfg_ext;
		end
	end

	assign dchain[0] = 1'b0;
	assign replace   = !dchain[FRAMES];

	for (genvar i = 0; i < FRAMES; i++) begin : g_cell
		logic [PAGE_BITS-1:0] nbr;

		if (i < FRAMES - 1) begin : g_mid
			assign nbr = frames[i+1];
		end else begin : g_end
			assign nbr = '0;
		end

		always_comb begin
			ctl[i].update  = accept;
			ctl[i].replace = replace;
			ctl[i].in_use  = (CW'(i) < n_use);
			ctl[i].tail    = (CW'(i) == n_use - CW'(1));
		end

		fpr_cell #(
			.PAGE_BITS(PAGE_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl[i]),
			.page      (page_number),
			.next_frame(nbr),
			.decided_in(dchain[i]),
			.stat      (stat[i]),
			.frame     (frames[i])
		);

		assign dchain[i+1] = stat[i].decided;
		assign hit_vec[i]  = stat[i].hit;
		assign load_vec[i] = stat[i].load;
	end

	assign hit_any  = |hit_vec;
	assign load_any = |load_vec;

	always_comb begin
		if (hit_any) begin
			outcome_next = OUTCOME_HIT;
		end else if (load_any) begin
			outcome_next = OUTCOME_LOAD;
		end else begin
			outcome_next = OUTCOME_REPLACE;
		end
	end

	fpr_tally u_tally (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.fault       (!hit_any),
		.fault_next  (fault_next),
		.request_next(request_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FRAME_COUNT_RST;
		end else if (cfg_write) begin
			frame_count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			outcome_q       <= outcome_next;
			evicted_q       <= replace ? frames[0] : '0;
			fault_total_q   <= fault_next;
			request_total_q <= request_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign outcome       = outcome_q;
	assign evicted_page  = evicted_q;
	assign fault_total   = fault_total_q;
	assign request_total = request_total_q;

	a_one_claim: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({hit_vec, load_vec}))
		else $error("More than one frame cell claimed the page.");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("An accepted transaction did not produce a result.");

	a_fault_counted: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !hit_any |=> fault_total != '0)
		else $error("A fault left the fault total at zero.");

	a_evict_only_on_replace: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (outcome != OUTCOME_REPLACE) |-> evicted_page == '0)
		else $error("An evicted page was reported without a replacement.");

endmodule

>>> tb/fpr_result_checker.sv
`timescale 1ns / 100ps
// Checker for the FIFO page replacement core: predicts each result from the accepted pages and compares it.
module fpr_result_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [fpr_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic [fpr_pkg::PAGE_BITS_DEF-1:0]   page_number,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [1:0]                          outcome,
	input  logic [fpr_pkg::PAGE_BITS_DEF-1:0]   evicted_page,
	input  logic [fpr_pkg::TOTAL_W-1:0]         fault_total,
	input  logic [fpr_pkg::TOTAL_W-1:0]         request_total,
	output int                                  mismatches,
	output int                                  pending_results,
	output int                                  hit_tally,
	output int                                  load_tally,
	output int                                  replace_tally
);

	localparam int SLOTS = fpr_pkg::FRAMES_DEF;
	localparam int PAGE_W = fpr_pkg::PAGE_BITS_DEF;
	localparam int TOT_W = fpr_pkg::TOTAL_W;

	typedef struct packed {
		fpr_pkg::outcome_t outcome;
		logic [PAGE_W-1:0] evicted;
		logic [TOT_W-1:0]  faults;
		logic [TOT_W-1:0]  requests;
	} page_result_t;

	logic [PAGE_W-1:0] resident [SLOTS];
	logic [TOT_W-1:0] fault_sum;
	logic [TOT_W-1:0] request_sum;
	logic [fpr_pkg::CFG_W-1:0] frame_setting;
	page_result_t awaited [$];

	function automatic logic [TOT_W-1:0] bump(input logic [TOT_W-1:0] value);
		return (value == '1) ? value : value + 1'b1;
	endfunction

	function automatic page_result_t reference_page(input logic [PAGE_W-1:0] page);
		int used;
		int slot;
		bit decided;
		page_result_t res;
		if (frame_setting == '0)
			used = 1;
		else if (frame_setting > SLOTS)
			used = SLOTS;
		else
			used = int'(frame_setting);
		res.outcome = fpr_pkg::OUTCOME_REPLACE;
		res.evicted = '0;
		decided = 1'b0;
		request_sum = bump(request_sum);
		for (slot = 0; slot < used && !decided; slot++) begin
			if (resident[slot] == page) begin
				res.outcome = fpr_pkg::OUTCOME_HIT;
				decided = 1'b1;
			end else if (resident[slot] == '0) begin
				resident[slot] = page;
				res.outcome = fpr_pkg::OUTCOME_LOAD;
				decided = 1'b1;
			end
		end
		if (!decided) begin
			res.evicted = resident[0];
			for (slot = 0; slot < used - 1; slot++)
				resident[slot] = resident[slot + 1];
			resident[used - 1] = page;
		end
		if (res.outcome != fpr_pkg::OUTCOME_HIT)
			fault_sum = bump(fault_sum);
		res.faults = fault_sum;
		res.requests = request_sum;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		page_result_t want;
		if (!arst_n) begin
			foreach (resident[i])
				resident[i] = '0;
			fault_sum = '0;
			request_sum = '0;
			frame_setting = fpr_pkg::FRAME_COUNT_RST;
			awaited.delete();
			pending_results = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited.size() == 0) begin
					$error("result transaction with nothing pending: outcome %0d, evicted_page %0d",
						outcome, evicted_page);
					mismatches++;
				end else begin
					want = awaited.pop_front();
					if (outcome !== want.outcome) begin
						$error("outcome: expected %0d, actual %0d", want.outcome, outcome);
						mismatches++;
					end
					if (evicted_page !== want.evicted) begin
						$error("evicted_page: expected %0d, actual %0d", want.evicted, evicted_page);
						mismatches++;
					end
					if (fault_total !== want.faults) begin
						$error("fault_total: expected %0d, actual %0d", want.faults, fault_total);
						mismatches++;
					end
					if (request_total !== want.requests) begin
						$error("request_total: expected %0d, actual %0d", want.requests,
							request_total);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				want = reference_page(page_number);
				awaited.push_back(want);
				case (want.outcome)
					fpr_pkg::OUTCOME_HIT: hit_tally++;
					fpr_pkg::OUTCOME_LOAD: load_tally++;
					default: replace_tally++;
				endcase
			end
			if (cfg_write)
				frame_setting = cfg_data;
			pending_results = awaited.size();
		end
	end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Top of the FIFO page replacement testbench: clock, reset, page and frame count stimulus, verdict.
module testbench;

	localparam int PAGE_W = fpr_pkg::PAGE_BITS_DEF;
	localparam int CFG_W = fpr_pkg::CFG_W;
	localparam int TOT_W = fpr_pkg::TOTAL_W;
	localparam int STUCK_LIMIT = 1000;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [PAGE_W-1:0] page_number;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] outcome;
	logic [PAGE_W-1:0] evicted_page;
	logic [TOT_W-1:0] fault_total;
	logic [TOT_W-1:0] request_total;

	int mismatches;
	int pending_results;
	int hit_tally;
	int load_tally;
	int replace_tally;
	int stuck_cycles = 0;
	int frames_used = 4;
	bit quiet = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	fifo_page_replacement_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.page_number  (page_number),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.outcome      (outcome),
		.evicted_page (evicted_page),
		.fault_total  (fault_total),
		.request_total(request_total)
	);

	fpr_result_checker result_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.page_number    (page_number),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.outcome        (outcome),
		.evicted_page   (evicted_page),
		.fault_total    (fault_total),
		.request_total  (request_total),
		.mismatches     (mismatches),
		.pending_results(pending_results),
		.hit_tally      (hit_tally),
		.load_tally     (load_tally),
		.replace_tally  (replace_tally)
	);

	function automatic bit take_break();
		return !quiet && ($urandom_range(0, 99) < 20);
	endfunction

	always @(posedge clk)
		out_stall <= take_break();

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_page(input logic [PAGE_W-1:0] page);
		while (take_break()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		page_number <= page;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
	endtask

	task automatic set_frames(input logic [CFG_W-1:0] value);
		drain();
		cfg_write <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (value == '0)
			frames_used = 1;
		else if (value > fpr_pkg::FRAMES_DEF)
			frames_used = fpr_pkg::FRAMES_DEF;
		else
			frames_used = int'(value);
	endtask

	function automatic logic [PAGE_W-1:0] pick_page(input int base, input int span);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 4)
			return '0;
		if (roll < 14)
			return PAGE_W'($urandom_range(1, 65535));
		return PAGE_W'(base + $urandom_range(0, span));
	endfunction

	initial begin
		int phase_frames [12] = '{2, 5, 16, 1, 8, 0, 3, 31, 12, 17, 6, 4};
		int base;
		int span;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		page_number = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_page(16'd1);
		send_page(16'hFFFF);
		send_page(16'd0);
		send_page(16'h5555);
		send_page(16'hAAAA);
		send_page(16'd1);
		send_page(16'd7);
		send_page(16'd0);
		send_page(16'd9);
		set_frames(5'd0);
		send_page(16'd3);
		send_page(16'd3);
		send_page(16'd0);
		send_page(16'd8);
		set_frames(5'd31);
		send_page(16'h8000);
		send_page(16'h7FFF);
		set_frames(5'd16);
		send_page(16'hFFFF);
		send_page(16'd1);

		for (int phase = 0; phase < 12; phase++) begin
			set_frames(CFG_W'(phase_frames[phase]));
			quiet = (phase == 4 || phase == 5);
			span = frames_used + frames_used / 2 + 1;
			base = $urandom_range(1, 65535 - span);
			repeat (50)
				send_page(pick_page(base, span));
		end
		quiet = 1'b0;

		drain();
		repeat (4) @(posedge clk);
		$display("Checked %0d page references: %0d hits, %0d loads, %0d replacements.",
			hit_tally + load_tally + replace_tally, hit_tally, load_tally, replace_tally);
		$display("Frame counts of zero, in range and above the frame total were used, %s",
			"with page zero and full-width pages.");
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
